// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every rising clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    // Screen geometry.
    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int COL_AW     = $clog2(COLUMNS);
    localparam int CELL_AW    = $clog2(CELL_COUNT);

    // Field widths of the transfers.
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = ATTR_W + CHAR_W;
    localparam int ROW_FW  = 5;
    localparam int COL_FW  = 7;
    localparam int IDX_FW  = 11;

    // Tab stops sit on multiples of 2**TAB_BITS.
    localparam int TAB_BITS = 3;
    localparam int TAB_STEP = 1 << TAB_BITS;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CHAR_SPACE};

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // Work the back end carries out for one item.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUT,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_COPY_END,
        ST_FILL,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_byte;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_col;
        logic [IDX_FW-1:0] cursor_index;
        logic [CELL_W-1:0] cell_data;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic              scroll;
        logic [CELL_AW-1:0] addr;
        logic [CHAR_W-1:0] char_byte;
        t_out_item         result;
    } t_cmd_entry;

    // Linear cell address of a row and column.
    function automatic logic [CELL_AW-1:0] cell_index(
        input logic [ROW_AW-1:0] row,
        input logic [COL_AW-1:0] col
    );
        cell_index = CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
    endfunction

endpackage

// ----- rtl/core/tcw_front.sv -----
module tcw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcw_pkg::t_in_item     i_in_data,
    input  logic                  i_queue_full,
    input  logic                  i_init_busy,
    output logic                  o_push,
    output tcw_pkg::t_cmd_entry   o_entry
);

    logic [tcw_pkg::ROW_AW-1:0]  r_row;
    logic [tcw_pkg::COL_AW-1:0]  r_col;
    logic [tcw_pkg::ROW_AW-1:0]  n_row;
    logic [tcw_pkg::COL_AW-1:0]  n_col;

    logic                        w_accept;
    logic                        w_printable;
    logic                        w_write;
    logic                        w_col_wrap;
    logic                        w_scroll;
    logic [tcw_pkg::COL_AW:0]    w_col_sum;
    logic [tcw_pkg::COL_AW:0]    w_col_t;
    logic [tcw_pkg::ROW_AW:0]    w_row_t;
    logic [tcw_pkg::ROW_AW:0]    w_row_w;
    logic [tcw_pkg::ROW_AW-1:0]  w_put_row;
    logic [tcw_pkg::COL_AW-1:0]  w_put_col;
    tcw_pkg::t_op                w_op;
    logic                        w_op_scroll;
    logic [tcw_pkg::CELL_AW-1:0] w_addr;

    // Hold off transfers while the queue is full or the screen is being initialized.
    assign o_in_stall = i_queue_full || i_init_busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = w_accept;

    // Cursor movement for a put-character command.
    always_comb begin
        w_col_t     = {1'b0, r_col};
        w_row_t     = {1'b0, r_row};
        w_write     = 1'b0;
        w_col_sum   = {1'b0, r_col} + (tcw_pkg::COL_AW + 1)'(tcw_pkg::TAB_STEP);
        w_printable = (i_in_data.char_byte >= tcw_pkg::CHAR_SPACE) && !i_in_data.char_byte[7];
        unique case (i_in_data.char_byte)
            tcw_pkg::CHAR_BS: begin
                if (r_col != '0) begin
                    w_col_t = {1'b0, r_col} - (tcw_pkg::COL_AW + 1)'(1);
                end
            end
            tcw_pkg::CHAR_TAB: begin
                w_col_t = {w_col_sum[tcw_pkg::COL_AW:tcw_pkg::TAB_BITS],
                           {tcw_pkg::TAB_BITS{1'b0}}};
            end
            tcw_pkg::CHAR_CR: begin
                w_col_t = '0;
            end
            tcw_pkg::CHAR_LF: begin
                w_row_t = {1'b0, r_row} + (tcw_pkg::ROW_AW + 1)'(1);
                w_col_t = '0;
            end
            default: begin
                if (w_printable) begin
                    w_write = 1'b1;
                    w_col_t = {1'b0, r_col} + (tcw_pkg::COL_AW + 1)'(1);
                end
            end
        endcase
        w_col_wrap = w_col_t >= (tcw_pkg::COL_AW + 1)'(tcw_pkg::COLUMNS);
        w_row_w    = w_row_t + (tcw_pkg::ROW_AW + 1)'(w_col_wrap);
        w_scroll   = w_row_w >= (tcw_pkg::ROW_AW + 1)'(tcw_pkg::ROWS);
        w_put_row  = w_scroll ? tcw_pkg::ROW_AW'(tcw_pkg::ROWS - 1)
                              : w_row_w[tcw_pkg::ROW_AW-1:0];
        w_put_col  = w_col_wrap ? '0 : w_col_t[tcw_pkg::COL_AW-1:0];
    end

    // Command decode: new cursor and the work handed to the back end.
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        w_op        = tcw_pkg::OP_NONE;
        w_op_scroll = 1'b0;
        w_addr      = tcw_pkg::cell_index(r_row, r_col);
        unique case (i_in_data.cmd)
            tcw_pkg::CMD_PUT: begin
                n_row       = w_put_row;
                n_col       = w_put_col;
                w_op        = w_write ? tcw_pkg::OP_PUT : tcw_pkg::OP_NONE;
                w_op_scroll = w_scroll;
            end
            tcw_pkg::CMD_CLEAR: begin
                n_row = '0;
                n_col = '0;
                w_op  = tcw_pkg::OP_CLEAR;
            end
            tcw_pkg::CMD_READ: begin
                if ((i_in_data.read_row < tcw_pkg::ROWS)
                        && (i_in_data.read_col < tcw_pkg::COLUMNS)) begin
                    w_op   = tcw_pkg::OP_READ;
                    w_addr = tcw_pkg::cell_index(tcw_pkg::ROW_AW'(i_in_data.read_row),
                                                 tcw_pkg::COL_AW'(i_in_data.read_col));
                end
            end
            default: begin
            end
        endcase
    end

    // Queue entry, with the cursor report already filled in.
    always_comb begin
        o_entry.op                  = w_op;
        o_entry.scroll              = w_op_scroll;
        o_entry.addr                = w_addr;
        o_entry.char_byte           = i_in_data.char_byte;
        o_entry.result.cursor_row   = tcw_pkg::ROW_FW'(n_row);
        o_entry.result.cursor_col   = tcw_pkg::COL_FW'(n_col);
        o_entry.result.cursor_index = tcw_pkg::IDX_FW'(tcw_pkg::cell_index(n_row, n_col));
        o_entry.result.cell_data    = '0;
    end

    // Cursor register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ----- rtl/core/tcw_queue.sv -----
module tcw_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tcw_pkg::t_cmd_entry  i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tcw_pkg::t_cmd_entry  o_entry
);

    tcw_pkg::t_cmd_entry           r_slot [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [tcw_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [tcw_pkg::QUEUE_AW:0]    r_count;

    assign o_full  = r_count == (tcw_pkg::QUEUE_AW + 1)'(tcw_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_entry = r_slot[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tcw_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tcw_pkg::QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (tcw_pkg::QUEUE_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (tcw_pkg::QUEUE_AW + 1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/core/tcw_back.sv -----
module tcw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_data,
    input  logic                       i_empty,
    input  tcw_pkg::t_cmd_entry        i_entry,
    output logic                       o_pop,
    output logic                       o_init_busy,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tcw_pkg::t_out_item         o_out_data
);

    tcw_pkg::t_back_state         r_state;
    tcw_pkg::t_back_state         n_state;
    logic [tcw_pkg::ATTR_W-1:0]   r_attr;
    tcw_pkg::t_cmd_entry          r_cur;
    logic [tcw_pkg::CELL_AW-1:0]  r_addr;
    logic [tcw_pkg::CELL_W-1:0]   r_fill_data;
    logic                         r_pend;
    logic [tcw_pkg::CELL_AW-1:0]  r_pend_addr;
    logic [tcw_pkg::CELL_W-1:0]   r_cell;
    logic                         r_out_valid;
    tcw_pkg::t_out_item           r_out_data;

    logic [tcw_pkg::CELL_W-1:0]   r_mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0]   r_rdata;

    logic                         w_last;
    logic                         w_we;
    logic [tcw_pkg::CELL_AW-1:0]  w_waddr;
    logic [tcw_pkg::CELL_W-1:0]   w_wdata;
    logic [tcw_pkg::CELL_AW-1:0]  w_raddr;
    logic                         w_load;
    tcw_pkg::t_out_item           w_result;

    assign w_last      = r_addr == tcw_pkg::CELL_AW'(tcw_pkg::CELL_COUNT - 1);
    assign o_init_busy = r_state == tcw_pkg::ST_INIT;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                if (w_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                unique case (r_cur.op)
                    tcw_pkg::OP_CLEAR: n_state = tcw_pkg::ST_FILL;
                    tcw_pkg::OP_READ:  n_state = tcw_pkg::ST_READ;
                    default: begin
                        n_state = r_cur.scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_READ: begin
                n_state = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_COPY: begin
                if (w_last) begin
                    n_state = tcw_pkg::ST_COPY_END;
                end
            end
            tcw_pkg::ST_COPY_END: begin
                n_state = tcw_pkg::ST_FILL;
            end
            tcw_pkg::ST_FILL: begin
                if (w_last) begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_INIT;
            end
        endcase
    end

    // State outputs: queue pop, memory ports and result load.
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_fill_data;
        w_raddr = r_addr;
        w_load  = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
                w_we = 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                o_pop = !i_empty;
            end
            tcw_pkg::ST_EXEC: begin
                if (r_cur.op == tcw_pkg::OP_PUT) begin
                    w_we    = 1'b1;
                    w_waddr = r_cur.addr;
                    w_wdata = {r_attr, r_cur.char_byte};
                end
                w_raddr = r_cur.addr;
            end
            tcw_pkg::ST_COPY, tcw_pkg::ST_COPY_END: begin
                w_we    = r_pend;
                w_waddr = r_pend_addr;
                w_wdata = r_rdata;
            end
            tcw_pkg::ST_DONE: begin
                w_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // Result of the current item with the read cell merged in.
    always_comb begin
        w_result           = r_cur.result;
        w_result.cell_data = r_cell;
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_addr      <= '0;
            r_fill_data <= tcw_pkg::RESET_BLANK;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (o_pop) begin
                r_cur  <= i_entry;
                r_cell <= '0;
            end
            unique case (r_state)
                tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
                    r_addr <= r_addr + tcw_pkg::CELL_AW'(1);
                end
                tcw_pkg::ST_EXEC: begin
                    // Clear starts at the top; a scroll reads from the second row.
                    if (r_cur.op == tcw_pkg::OP_CLEAR) begin
                        r_addr      <= '0;
                        r_fill_data <= {r_attr, tcw_pkg::CHAR_SPACE};
                    end else begin
                        r_addr <= tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS);
                    end
                    r_pend <= 1'b0;
                end
                tcw_pkg::ST_READ: begin
                    r_cell <= r_rdata;
                end
                tcw_pkg::ST_COPY: begin
                    // Each read lands one row higher on the following cycle.
                    r_pend      <= 1'b1;
                    r_pend_addr <= r_addr - tcw_pkg::CELL_AW'(tcw_pkg::COLUMNS);
                    r_addr      <= r_addr + tcw_pkg::CELL_AW'(1);
                end
                tcw_pkg::ST_COPY_END: begin
                    r_pend      <= 1'b0;
                    r_addr      <= tcw_pkg::CELL_AW'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
                    r_fill_data <= {r_attr, tcw_pkg::CHAR_SPACE};
                end
                default: begin
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_result;
        end
    end

    // Screen store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Text console writer.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per command:
// put character, clear screen or read one cell. Output channel (o_out_valid /
// i_out_stall / o_out_data): exactly one transfer per command, in order, with the
// cursor after the command, its linear index and the read cell (zero otherwise).
// i_cfg_we / i_cfg_data load the attribute byte used for written and blank cells;
// write it only while no command is in flight.
// Each command passes through the queue to the back end, which pops it in IDLE,
// carries it out in EXEC (a read adds READ) and loads the result in DONE. A scroll
// walks the store once through the screen memory, copying each row one row up and
// then blanking the last row, and a clear blanks every cell. Ordinary writes are
// paced by the back end's memory sequencer, which carries out one command at a time.
// A four-entry command queue lets new input be taken while a result waits.
// Reset (synchronous, active low) homes the cursor, sets the attribute to 0x0F and
// then runs a blanking pass over all ROWS*COLUMNS cells, one per cycle,
// during which o_in_stall stays high. When the receiver stalls, the output holds
// its result, the queue fills and then o_in_stall rises.

`include "assert_macros.svh"

module text_console_writer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tcw_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tcw_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_data
);

    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_init_busy;
    tcw_pkg::t_cmd_entry  w_push_entry;
    tcw_pkg::t_cmd_entry  w_pop_entry;
    logic                 w_index_ok;
    logic                 w_cursor_ok;
    logic                 w_init_quiet;

    // Front end: cursor tracking and command decode.
    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (w_full),
        .i_init_busy  (w_init_busy),
        .o_push       (w_push),
        .o_entry      (w_push_entry)
    );

    // Command queue between the two halves.
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_pop_entry)
    );

    // Back end: screen memory sequencer and result register.
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (w_empty),
        .i_entry     (w_pop_entry),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Conditions checked on the result payload and during the blanking pass.
    assign w_index_ok   = o_out_data.cursor_index == tcw_pkg::IDX_FW'(tcw_pkg::cell_index(
                              tcw_pkg::ROW_AW'(o_out_data.cursor_row),
                              tcw_pkg::COL_AW'(o_out_data.cursor_col)));
    assign w_cursor_ok  = (o_out_data.cursor_row < tcw_pkg::ROW_FW'(tcw_pkg::ROWS))
                       && (o_out_data.cursor_col < tcw_pkg::COL_FW'(tcw_pkg::COLUMNS));
    assign w_init_quiet = !(w_init_busy && (o_out_valid || !w_empty));

    // The reported index always matches the reported row and column.
    `TCW_ASSERT_IMPLIES(a_index_match, i_clk, i_rst_n, o_out_valid, w_index_ok, "bad cursor index")
    // The reported cursor stays on the screen.
    `TCW_ASSERT_IMPLIES(a_cursor_range, i_clk, i_rst_n, o_out_valid, w_cursor_ok, "cursor off screen")
    // No result can appear while the reset blanking pass runs.
    `TCW_ASSERT_ALWAYS(a_init_quiet, i_clk, i_rst_n, w_init_quiet, "activity during blanking pass")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 4;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 250;
    // The receiver holds off once, after this many results, for this long.
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_LIMIT  = 40;

    // Command code that the block has no operation for.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Directed rows either carry a typed expectation or go through the console model.
    localparam bit CHECK_TYPED = 1'b1;
    localparam bit CHECK_MODEL = 1'b0;

    localparam t_out_item HOME_BLANK = {5'd0, 7'd0, 11'd0, RESET_BLANK};
    localparam t_out_item HOME_EMPTY = '0;

    typedef struct {
        t_in_item  item;
        int        count;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                i_cfg_we;
    logic [ATTR_W-1:0]   i_cfg_data;

    // Shadow copy of the screen, the cursor and the attribute register.
    logic [CELL_W-1:0]   shadow_cells [CELL_COUNT];
    int                  shadow_row;
    int                  shadow_col;
    logic [ATTR_W-1:0]   shadow_attr;

    t_out_item           pending_results [$];
    t_directed_row       directed_rows [$];

    int burst_left      = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int put_count       = 0;
    int clear_count     = 0;
    int read_count      = 0;
    int offscreen_count = 0;
    int scroll_count    = 0;
    int attr_settings   = 1;

    text_console_writer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Runs one command through the shadow console and returns the cursor report it causes.
    function automatic t_out_item console_predict(input t_in_item item);
        t_out_item          res;
        logic [CELL_W-1:0]  blank;
        int                 k;
        res   = '0;
        blank = {shadow_attr, CHAR_SPACE};
        case (item.cmd)
            CMD_PUT: begin
                put_count++;
                if (item.char_byte == CHAR_BS) begin
                    if (shadow_col > 0) shadow_col--;
                end else if (item.char_byte == CHAR_TAB) begin
                    shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
                end else if (item.char_byte == CHAR_CR) begin
                    shadow_col = 0;
                end else if (item.char_byte == CHAR_LF) begin
                    shadow_row++;
                    shadow_col = 0;
                end else if (item.char_byte >= CHAR_SPACE && !item.char_byte[CHAR_W-1]) begin
                    shadow_cells[shadow_row * COLUMNS + shadow_col] =
                        {shadow_attr, item.char_byte};
                    shadow_col++;
                end
                // Running off the end of a row wraps to the next one.
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // Falling off the bottom moves everything up a row and blanks the last one.
                if (shadow_row >= ROWS) begin
                    for (k = 0; k < (ROWS - 1) * COLUMNS; k++) begin
                        shadow_cells[k] = shadow_cells[k + COLUMNS];
                    end
                    for (k = (ROWS - 1) * COLUMNS; k < CELL_COUNT; k++) begin
                        shadow_cells[k] = blank;
                    end
                    shadow_row = ROWS - 1;
                    scroll_count++;
                end
            end
            CMD_CLEAR: begin
                clear_count++;
                foreach (shadow_cells[k]) shadow_cells[k] = blank;
                shadow_row = 0;
                shadow_col = 0;
            end
            CMD_READ: begin
                read_count++;
                if (item.read_row < ROWS && item.read_col < COLUMNS) begin
                    res.cell_data = shadow_cells[item.read_row * COLUMNS + item.read_col];
                end else begin
                    offscreen_count++;
                end
            end
            default: begin
            end
        endcase
        res.cursor_row   = ROW_FW'(shadow_row);
        res.cursor_col   = COL_FW'(shadow_col);
        res.cursor_index = IDX_FW'(shadow_row * COLUMNS + shadow_col);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
        end
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input int rr, input int rc, input int count,
                           input bit typed, input t_out_item want);
        t_directed_row r;
        r.item.cmd       = cmd;
        r.item.char_byte = ch;
        r.item.read_row  = ROW_FW'(rr);
        r.item.read_col  = COL_FW'(rc);
        r.count          = count;
        r.typed          = typed;
        r.want           = want;
        directed_rows.push_back(r);
    endtask

    // Offers one command in the sender's burst pattern and records its expected result.
    task automatic send_item(input t_in_item item, input bit typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = console_predict(item);
        pending_results.push_back(typed ? want : predicted);
        commands_sent++;
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        settle_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_attr = value;
        attr_settings++;
    endtask

    // Command side: reset, directed rows, then random phases under different attributes.
    initial begin
        t_in_item          item;
        t_directed_row     row_spec;
        logic [ATTR_W-1:0] phase_attr;
        int                pick;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        shadow_attr = ATTR_RESET;
        foreach (shadow_cells[k]) shadow_cells[k] = RESET_BLANK;
        shadow_row = 0;
        shadow_col = 0;

        // Fresh screen, reads off the edges, the unused command code and a backspace at home.
        add_row(CMD_READ, '0, 0, 0, 1, CHECK_TYPED, HOME_BLANK);
        add_row(CMD_READ, '0, ROWS - 1, COLUMNS - 1, 1, CHECK_TYPED, HOME_BLANK);
        add_row(CMD_READ, '0, ROWS, 0, 1, CHECK_TYPED, HOME_EMPTY);
        add_row(CMD_READ, '0, 0, COLUMNS, 1, CHECK_TYPED, HOME_EMPTY);
        add_row(CMD_UNUSED, 8'hFF, 2**ROW_FW - 1, 2**COL_FW - 1, 1, CHECK_TYPED, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_BS, 2**ROW_FW - 1, 2**COL_FW - 1, 1, CHECK_TYPED, HOME_EMPTY);
        // Printable extremes, ignored bytes and each control character, then reads and a clear.
        add_row(CMD_PUT, 8'h41, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'h7F, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'h80, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'hFF, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'h00, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_TAB, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_SPACE, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_BS, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_CR, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_LF, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_READ, '0, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_READ, '0, 0, 1, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_CLEAR, '0, 0, 0, 1, CHECK_TYPED, HOME_EMPTY);
        add_row(CMD_READ, '0, 0, 0, 1, CHECK_TYPED, HOME_BLANK);
        // Down to the last row, then a tab wrap, a column wrap and a line feed that all scroll.
        add_row(CMD_PUT, CHAR_LF, 0, 0, ROWS - 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_TAB, 0, 0, COLUMNS / TAB_STEP - 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'h5A, 0, 0, TAB_STEP - 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_TAB, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, 8'h51, 0, 0, COLUMNS, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_PUT, CHAR_LF, 0, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_READ, '0, ROWS - 4, COLUMNS - 2, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_READ, '0, ROWS - 3, 0, 1, CHECK_MODEL, HOME_EMPTY);
        add_row(CMD_READ, '0, ROWS - 1, COLUMNS - 1, 1, CHECK_MODEL, HOME_EMPTY);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row_spec = directed_rows[r];
            repeat (row_spec.count) send_item(row_spec.item, row_spec.typed, row_spec.want);
        end

        // Mostly text with line control, plus reads near the cursor and some noise.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) phase_attr = '0;
            else if (phase == 1) phase_attr = '1;
            else phase_attr = ATTR_W'($urandom);
            write_attribute(phase_attr);
            repeat (PHASE_ITEMS) begin
                pick           = $urandom_range(0, 999);
                item.cmd       = CMD_PUT;
                item.char_byte = CHAR_W'($urandom);
                item.read_row  = ROW_FW'($urandom);
                item.read_col  = COL_FW'($urandom);
                if (pick < 550) begin
                    item.char_byte = CHAR_W'($urandom_range(CHAR_SPACE, 8'h7F));
                end else if (pick < 590) begin
                    item.char_byte = CHAR_LF;
                end else if (pick < 620) begin
                    item.char_byte = CHAR_CR;
                end else if (pick < 670) begin
                    item.char_byte = CHAR_TAB;
                end else if (pick < 700) begin
                    item.char_byte = CHAR_BS;
                end else if (pick < 740) begin
                    item.char_byte = pick[0] ? {1'b1, 7'($urandom)} : {3'b000, 5'($urandom)};
                end else if (pick < 890) begin
                    item.cmd      = CMD_READ;
                    item.read_row = pick[0] ? ROW_FW'(shadow_row)
                                            : ROW_FW'($urandom_range(0, ROWS - 1));
                    item.read_col = COL_FW'($urandom_range(0, COLUMNS - 1));
                end else if (pick < 920) begin
                    item.cmd = CMD_READ;
                    if (pick[0]) item.read_row = ROW_FW'($urandom_range(ROWS, 2**ROW_FW - 1));
                    else item.read_col = COL_FW'($urandom_range(COLUMNS, 2**COL_FW - 1));
                end else if (pick < 922) begin
                    item.cmd = CMD_CLEAR;
                end else if (pick < 940) begin
                    item.cmd = CMD_UNUSED;
                end
                send_item(item, CHECK_MODEL, HOME_EMPTY);
            end
        end

        settle_idle();
        $display("Sent %0d commands: %0d puts, %0d clears, %0d reads (%0d off screen),",
                 commands_sent, put_count, clear_count, read_count, offscreen_count);
        $display("%0d scrolls, %0d attribute settings including 0x00 and 0xFF; %0d mismatches.",
                 scroll_count, attr_settings, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: checks each transfer and stalls on a pattern of its own.
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        bit  stall_next;
        t_out_item want;
        i_out_stall <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no command outstanding", o_out_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", o_out_data.cursor_row, want.cursor_row);
                    if (o_out_data.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", o_out_data.cursor_col, want.cursor_col);
                    if (o_out_data.cursor_index !== want.cursor_index)
                        report_mismatch("cursor_index", o_out_data.cursor_index,
                                        want.cursor_index);
                    if (o_out_data.cell_data !== want.cell_data)
                        report_mismatch("cell_data", o_out_data.cell_data, want.cell_data);
                end
                results_checked++;
            end

            // One long hold-off so the command queue fills and the input stalls.
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else begin
                case (mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 3) != 0);
                    default: stall_next = mode_left[0];
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    // Generous bound on the whole run; scrolls and clears dominate its length.
    initial begin
        #3_000_000;
        $display("Timed out with %0d results outstanding after %0d checked.",
                 pending_results.size(), results_checked);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
